// ----- hdl/fir_pkg.sv -----
package fir_pkg;

  // Filter size and field widths.
  localparam int TAPS    = 16;
  localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = 2 * SMP_W;
  localparam int ACC_W   = PROD_W + TAP_W;
  localparam int SCALE_W = 15;
  localparam int NTAP_W  = 5;
  localparam int IDX_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = (ACC_W + 1) / 2;
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Saturation bounds of the 16-bit result.
  localparam int SAT_POS     = 32767;
  localparam int SAT_NEG_MAG = 32768;

  // Item modes.
  localparam logic MODE_COEF = 1'b0;
  localparam logic MODE_FILT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SCALE_W-1:0] SCALE_RST = 15'd1;
  localparam logic [NTAP_W-1:0]  TAPS_RST  = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DIV_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic coef_wr;
    logic sample_wr;
    logic mul;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tap_last;
    logic div_last;
  } status_t;

endpackage

// ----- hdl/fir_filter_int16.sv -----
// Direct-form FIR filter for signed 16-bit samples.
// Input channel (item_valid / item_stall): mode 1 items carry a sample to
// filter, mode 0 items write one coefficient at tap_index and give no result.
// An item is taken at a clock edge with item_valid high and item_stall low.
// Output channel (result_valid / result_stall): one filtered_sample per
// mode 1 item, held in an output register until the receiver takes it.
// A filtered item runs a tap sweep of one multiply per tap in use, then drains
// the last product, loads the divider and runs the divider at two quotient
// bits per step before result_valid rises; the next item can be taken in the
// cycle after result_valid rises. A coefficient item leaves the block idle,
// ready for the next item.
// A stalled receiver holds the result; the block still takes the next item
// and only waits at the end of that item if the old result is still held.
// The user must write configuration (cfg_wr_en / cfg_index / cfg_data) only
// while idle (not enforced): index 0 is scale_divisor, index 1 is taps_in_use.
// Synchronous reset clears the delay line and coefficients, sets the divisor
// to 1 and the tap count to 16, and empties the output register.
module fir_filter_int16 (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [fir_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [fir_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    item_valid,
  output logic                                    item_stall,
  input  logic                                    mode,
  input  logic [fir_pkg::IDX_W-1:0]               tap_index,
  input  logic signed [fir_pkg::SMP_W-1:0]        coefficient,
  input  logic signed [fir_pkg::SMP_W-1:0]        sample,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [fir_pkg::SMP_W-1:0]        filtered_sample
);

  fir_pkg::cmd_t    cmd;
  fir_pkg::status_t status;

  // Sequencer.
  fir_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Storage, multiply-accumulate and divider.
  fir_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .tap_index       (tap_index),
    .coefficient     (coefficient),
    .sample          (sample),
    .filtered_sample (filtered_sample)
  );

endmodule

// ----- hdl/fir_ctrl.sv -----
module fir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 mode,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  fir_pkg::status_t     status,
  output fir_pkg::cmd_t        cmd
);

  fir_pkg::state_t state, state_next;
  logic            result_valid_next;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fir_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // New items are taken only while no sample is being filtered.
  assign item_stall = (state != fir_pkg::S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      fir_pkg::S_IDLE: begin
        if (item_valid) begin
          if (mode == fir_pkg::MODE_FILT) begin
            cmd.sample_wr = 1'b1;
            state_next    = fir_pkg::S_MAC;
          end else begin
            cmd.coef_wr = 1'b1;
          end
        end
      end
      fir_pkg::S_MAC: begin
        cmd.mul = 1'b1;
        if (status.tap_last) begin
          state_next = fir_pkg::S_DRAIN;
        end
      end
      fir_pkg::S_DRAIN: begin
        state_next = fir_pkg::S_DIV_LOAD;
      end
      fir_pkg::S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = fir_pkg::S_DIV;
      end
      fir_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = fir_pkg::S_DONE;
        end
      end
      fir_pkg::S_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = fir_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fir_pkg::S_IDLE;
      end
    endcase
  end

  // The output register holds its item until the receiver takes it.
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  // A new result never overwrites one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  // An accepted sample always starts the tap sweep.
  a_sample_starts_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.sample_wr |=> state == fir_pkg::S_MAC)
    else $error("sample accepted without tap sweep");

  // The divider is loaded exactly after the last product has been added.
  a_drain_then_load: assert property (@(posedge clk) disable iff (rst)
    state == fir_pkg::S_DRAIN |=> cmd.div_load)
    else $error("divider not loaded after drain");

  // Items are only written into storage while the block is idle.
  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.coef_wr || cmd.sample_wr) |-> !item_stall)
    else $error("storage written while busy");

endmodule

// ----- hdl/fir_dp.sv -----
module fir_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fir_pkg::cmd_t                           cmd,
  output fir_pkg::status_t                        status,
  input  logic                                    cfg_wr_en,
  input  logic [fir_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [fir_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic [fir_pkg::IDX_W-1:0]               tap_index,
  input  logic signed [fir_pkg::SMP_W-1:0]        coefficient,
  input  logic signed [fir_pkg::SMP_W-1:0]        sample,
  output logic signed [fir_pkg::SMP_W-1:0]        filtered_sample
);

  // Configuration registers.
  logic [fir_pkg::SCALE_W-1:0] scale_divisor;
  logic [fir_pkg::NTAP_W-1:0]  taps_in_use;

  // Filter storage.
  logic signed [fir_pkg::SMP_W-1:0] coef_store [fir_pkg::TAPS];
  logic signed [fir_pkg::SMP_W-1:0] delay_line [fir_pkg::TAPS];
  logic [fir_pkg::TAP_W-1:0]        newest_pos, newest_pos_next;

  // Multiply-accumulate.
  logic [fir_pkg::TAP_W-1:0]         tap_cnt;
  logic [fir_pkg::TAP_W-1:0]         rd_pos;
  logic [fir_pkg::TAP_W-1:0]         last_tap;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic                              prod_vld;
  logic signed [fir_pkg::ACC_W-1:0]  acc;

  // Divider.
  logic [fir_pkg::SCALE_W-1:0] div_eff;
  logic [fir_pkg::DVD_W-1:0]   dvd, dvd_next;
  logic [fir_pkg::SCALE_W-1:0] rem, rem_next;
  logic [fir_pkg::DCNT_W-1:0]  div_cnt;
  logic                        neg;
  logic [fir_pkg::ACC_W-1:0]   acc_mag;
  logic [fir_pkg::SMP_W-1:0]   result;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_divisor <= fir_pkg::SCALE_RST;
      taps_in_use   <= fir_pkg::TAPS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fir_pkg::REG_SCALE: scale_divisor <= fir_pkg::SCALE_W'(cfg_data);
        fir_pkg::REG_TAPS:  taps_in_use   <= fir_pkg::NTAP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp the tap count to the range of the store.
  always_comb begin
    if (taps_in_use == '0) begin
      last_tap = '0;
    end else if (32'(taps_in_use) > fir_pkg::TAPS) begin
      last_tap = fir_pkg::TAP_W'(fir_pkg::TAPS - 1);
    end else begin
      last_tap = fir_pkg::TAP_W'(taps_in_use - 1'b1);
    end
  end

  assign div_eff = (scale_divisor == '0) ? fir_pkg::SCALE_W'(1) : scale_divisor;

  assign newest_pos_next = (32'(newest_pos) == fir_pkg::TAPS - 1) ?
                           '0 : newest_pos + 1'b1;

  // Coefficient store: one write port, one read at the tap counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fir_pkg::TAPS; i++) begin
        coef_store[i] <= '0;
      end
    end else if (cmd.coef_wr && (32'(tap_index) < fir_pkg::TAPS)) begin
      coef_store[fir_pkg::TAP_W'(tap_index)] <= coefficient;
    end
  end

  // Circular delay line; a new sample advances the newest position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fir_pkg::TAPS; i++) begin
        delay_line[i] <= '0;
      end
      newest_pos <= '0;
    end else if (cmd.sample_wr) begin
      delay_line[newest_pos_next] <= sample;
      newest_pos                  <= newest_pos_next;
    end
  end

  // Tap sweep: read position walks backward from the newest sample.
  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      tap_cnt <= '0;
      rd_pos  <= newest_pos_next;
    end else if (cmd.mul) begin
      tap_cnt <= tap_cnt + 1'b1;
      rd_pos  <= (rd_pos == '0) ? fir_pkg::TAP_W'(fir_pkg::TAPS - 1) : rd_pos - 1'b1;
    end
  end

  assign status.tap_last = (tap_cnt == last_tap);

  // One registered product per cycle, added to the accumulator the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= coef_store[tap_cnt] * delay_line[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + fir_pkg::ACC_W'(prod);
    end
  end

  // Magnitude of the sum for the unsigned divider.
  assign acc_mag = acc[fir_pkg::ACC_W-1] ? fir_pkg::ACC_W'(-acc) : fir_pkg::ACC_W'(acc);

  // Two restoring division steps per cycle; quotient bits shift into the dividend.
  always_comb begin
    logic [fir_pkg::SCALE_W:0] trial;
    rem_next = rem;
    dvd_next = dvd;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, dvd_next[fir_pkg::DVD_W-1]};
      dvd_next = {dvd_next[fir_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_eff}) begin
        rem_next    = fir_pkg::SCALE_W'(trial - {1'b0, div_eff});
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = trial[fir_pkg::SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd     <= fir_pkg::DVD_W'(acc_mag);
      rem     <= '0;
      neg     <= acc[fir_pkg::ACC_W-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= dvd_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.div_last = (32'(div_cnt) == fir_pkg::DIV_STEPS - 1);

  // Restore the sign and saturate to 16 bits.
  always_comb begin
    if (neg) begin
      if (dvd > fir_pkg::DVD_W'(fir_pkg::SAT_NEG_MAG)) begin
        result = fir_pkg::SMP_W'(fir_pkg::SAT_NEG_MAG);
      end else begin
        result = ~dvd[fir_pkg::SMP_W-1:0] + 1'b1;
      end
    end else begin
      if (dvd > fir_pkg::DVD_W'(fir_pkg::SAT_POS)) begin
        result = fir_pkg::SMP_W'(fir_pkg::SAT_POS);
      end else begin
        result = dvd[fir_pkg::SMP_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_sample <= result;
    end
  end

endmodule

// ----- tb/sv/fir_filter_int16_tb.sv -----
module fir_filter_int16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the block finish after the last result, before a register
  // write or the end of the run.
  localparam int SETTLE = 60;
  localparam int RAND_PHASE_ITEMS = 230;

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_wr_en;
  logic [fir_pkg::CFG_IDX_W-1:0]          cfg_index;
  logic [fir_pkg::CFG_DATA_W-1:0]         cfg_data;
  logic                                   item_valid;
  logic                                   item_stall;
  logic                                   mode;
  logic [fir_pkg::IDX_W-1:0]              tap_index;
  logic signed [fir_pkg::SMP_W-1:0]       coefficient;
  logic signed [fir_pkg::SMP_W-1:0]       sample;
  logic                                   result_valid;
  logic                                   result_stall;
  logic signed [fir_pkg::SMP_W-1:0]       filtered_sample;

  // Shadow copy of the filter state and its registers.
  logic signed [fir_pkg::SMP_W-1:0]       coef_shadow [fir_pkg::TAPS];
  logic signed [fir_pkg::SMP_W-1:0]       delay_shadow [fir_pkg::TAPS];
  int                                     newest_slot;
  logic [fir_pkg::SCALE_W-1:0]            divisor_shadow;
  logic [fir_pkg::NTAP_W-1:0]             tap_count_shadow;

  // Filter outputs predicted but not yet seen, oldest first.
  logic signed [fir_pkg::SMP_W-1:0]       pending_outputs [$];

  int mismatch_count;
  int filter_items;
  int coef_loads;
  int outputs_checked;
  int hold_req;
  bit tx_free;
  bit rx_free;

  fir_filter_int16 u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .tap_index       (tap_index),
    .coefficient     (coefficient),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .filtered_sample (filtered_sample)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shift the new sample in, form the exact sum, divide and saturate.
  function automatic logic signed [fir_pkg::SMP_W-1:0] filter_output(
    input logic signed [fir_pkg::SMP_W-1:0] smp
  );
    longint acc;
    longint quot;
    longint dvsr;
    int     n_taps;
    int     pos;
    newest_slot = (newest_slot + 1) % fir_pkg::TAPS;
    delay_shadow[newest_slot] = smp;
    n_taps = tap_count_shadow;
    if (n_taps < 1) n_taps = 1;
    if (n_taps > fir_pkg::TAPS) n_taps = fir_pkg::TAPS;
    acc = 0;
    pos = newest_slot;
    for (int i = 0; i < n_taps; i++) begin
      acc += longint'(coef_shadow[i]) * longint'(delay_shadow[pos]);
      pos = (pos + fir_pkg::TAPS - 1) % fir_pkg::TAPS;
    end
    dvsr = (divisor_shadow == '0) ? 1 : longint'(divisor_shadow);
    quot = acc / dvsr;
    if (quot > fir_pkg::SAT_POS) quot = fir_pkg::SAT_POS;
    if (quot < -fir_pkg::SAT_NEG_MAG) quot = -fir_pkg::SAT_NEG_MAG;
    return quot[fir_pkg::SMP_W-1:0];
  endfunction

  // A 16-bit value that favors the extremes now and then.
  function automatic logic signed [fir_pkg::SMP_W-1:0] rand_word();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return -16'sd1;
      4: return $signed(16'($urandom_range(0, 512))) - 16'sd256;
      default: return r[fir_pkg::SMP_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic signed [fir_pkg::SMP_W-1:0] want,
                                 input logic signed [fir_pkg::SMP_W-1:0] got);
    $display("%0t ns: mismatch on %s: wanted %0d, saw %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic m, input logic [fir_pkg::IDX_W-1:0] t,
                           input logic signed [fir_pkg::SMP_W-1:0] c,
                           input logic signed [fir_pkg::SMP_W-1:0] s);
    int gap;
    gap = tx_free ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    mode        <= m;
    tap_index   <= t;
    coefficient <= c;
    sample      <= s;
    do @(posedge clk); while (item_stall);
    if (m == fir_pkg::MODE_COEF) begin
      coef_shadow[t] = c;
      coef_loads++;
    end else begin
      pending_outputs.push_back(filter_output(s));
      filter_items++;
    end
  endtask

  task automatic send_filter(input logic signed [fir_pkg::SMP_W-1:0] s);
    send_item(fir_pkg::MODE_FILT, 4'($urandom()), rand_word(), s);
  endtask

  task automatic send_coef(input logic [fir_pkg::IDX_W-1:0] t,
                           input logic signed [fir_pkg::SMP_W-1:0] c);
    send_item(fir_pkg::MODE_COEF, t, c, rand_word());
  endtask

  // Stop offering items and wait for every predicted output to come back.
  task automatic pause_until_drained();
    item_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_filter_config(input logic [fir_pkg::CFG_DATA_W-1:0] divisor_val,
                                   input logic [fir_pkg::CFG_DATA_W-1:0] taps_val);
    pause_until_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= fir_pkg::REG_SCALE;
    cfg_data  <= divisor_val;
    @(posedge clk);
    cfg_index <= fir_pkg::REG_TAPS;
    cfg_data  <= taps_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    divisor_shadow   = divisor_val[fir_pkg::SCALE_W-1:0];
    tap_count_shadow = taps_val[fir_pkg::NTAP_W-1:0];
  endtask

  // With all coefficients zero after reset, every output is zero.
  task automatic test_reset_state();
    send_filter(16'sh7FFF);
    send_filter(16'sh8000);
  endtask

  // Extreme coefficients and samples, saturation in both directions.
  task automatic test_field_extremes();
    send_coef(4'd0, 16'sh7FFF);
    send_coef(4'd15, 16'sh8000);
    send_coef(4'd1, -16'sd1);
    send_item(fir_pkg::MODE_FILT, 4'd15, 16'sh8000, 16'sh7FFF);
    send_item(fir_pkg::MODE_FILT, 4'd0, 16'sh7FFF, 16'sh8000);
    send_item(fir_pkg::MODE_COEF, 4'd7, 16'sh0000, 16'sh7FFF);
    send_item(fir_pkg::MODE_COEF, 4'd8, 16'sh0003, 16'sh8000);
    send_filter(16'sd0);
    send_filter(-16'sd1);
    send_filter(16'sd1);
  endtask

  // Zero divisor, zero and oversized tap counts, largest divisor, rounding.
  task automatic test_config_extremes();
    set_filter_config(15'd0, 15'd0);
    send_filter(16'sh7FFF);
    send_filter(16'sh8000);
    set_filter_config(15'h7FFF, 15'h7FFF);
    send_filter(16'sh7FFF);
    send_filter(16'sh8000);
    set_filter_config(15'd3, 15'd1);
    send_coef(4'd0, -16'sd7);
    send_filter(16'sd1);
    send_filter(-16'sd1);
    set_filter_config(15'd1, 15'd16);
    send_filter(16'sd5);
  endtask

  // Random traffic under one register setting: a full coefficient load, then
  // mostly samples with an occasional coefficient update.
  task automatic run_random_phase(input logic [fir_pkg::CFG_DATA_W-1:0] divisor_val,
                                  input logic [fir_pkg::CFG_DATA_W-1:0] taps_val);
    int coef_shift;
    set_filter_config(divisor_val, taps_val);
    tx_free = ($urandom_range(0, 3) == 0);
    rx_free = ($urandom_range(0, 3) == 0);
    coef_shift = $urandom_range(0, 12);
    for (int i = 0; i < fir_pkg::TAPS; i++)
      send_coef(4'(i), rand_word() >>> coef_shift);
    for (int i = 0; i < RAND_PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 85)
        send_filter(rand_word());
      else
        send_coef(4'($urandom()), rand_word() >>> coef_shift);
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(15'd1, 15'd16);
    run_random_phase(15'd0, 15'd0);
    run_random_phase(15'h7FFF, 15'd16);
    run_random_phase(15'($urandom_range(1, 32767)), 15'd1);
    run_random_phase(15'($urandom()), 15'($urandom()));
    run_random_phase(15'($urandom_range(1, 64)), {10'($urandom()), 5'd31});
    run_random_phase(15'($urandom()), 15'($urandom_range(1, 16)));
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    hold_req = 400;
    tx_free  = 1'b1;
    for (int i = 0; i < 20; i++) send_filter(rand_word());
    tx_free  = 1'b0;
  endtask

  // The sender goes quiet until every output is back, then resumes.
  task automatic test_sender_pause();
    for (int i = 0; i < 8; i++) send_filter(rand_word());
    pause_until_drained();
    for (int i = 0; i < 8; i++) send_filter(rand_word());
  endtask

  // Main sequence.
  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    item_valid  <= 1'b0;
    mode        <= fir_pkg::MODE_COEF;
    tap_index   <= '0;
    coefficient <= '0;
    sample      <= '0;
    for (int i = 0; i < fir_pkg::TAPS; i++) begin
      coef_shadow[i]  = '0;
      delay_shadow[i] = '0;
    end
    newest_slot      = 0;
    divisor_shadow   = fir_pkg::SCALE_RST;
    tap_count_shadow = fir_pkg::TAPS_RST;
    mismatch_count   = 0;
    filter_items     = 0;
    coef_loads       = 0;
    outputs_checked  = 0;
    hold_req         = 0;
    tx_free          = 1'b0;
    rx_free          = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_config_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    pause_until_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d samples and %0d coefficient loads; %0d outputs compared.",
             filter_items, coef_loads, outputs_checked);
    $display("Divisor and tap count swept through zero, minimum, maximum and oversize values.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: after each output, stall for a random count of cycles, counted
  // either at once or only while an output is on offer; long holds on request.
  initial begin
    int stall_left;
    bit count_on_data;
    stall_left    = 0;
    count_on_data = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left    = hold_req;
        count_on_data = 1'b0;
        hold_req      = 0;
      end else if (!rst && result_valid && !result_stall) begin
        stall_left    = rx_free ? 0 : $urandom_range(0, 18);
        count_on_data = $urandom_range(0, 1);
      end
      result_stall <= (stall_left > 0);
      if (stall_left > 0 && (!count_on_data || result_valid)) stall_left--;
    end
  end

  // Compare each output taken against the oldest prediction.
  initial begin
    logic signed [fir_pkg::SMP_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_outputs.size() == 0) begin
          report_mismatch("filtered_sample with no sample pending", '0, filtered_sample);
        end else begin
          want = pending_outputs.pop_front();
          if (filtered_sample !== want)
            report_mismatch("filtered_sample", want, filtered_sample);
          outputs_checked++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Timeout with %0d outputs outstanding", pending_outputs.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- fir_filter_int16.f -----
hdl/fir_pkg.sv
hdl/fir_ctrl.sv
hdl/fir_dp.sv
hdl/fir_filter_int16.sv
tb/sv/fir_filter_int16_tb.sv
